>>> design/rfsp_pkg.sv
// ---------------------------------------------------------------------------
// RGB fade sequence player package
// Shared types, command kinds, micro-operation codes and built-in pattern
// tables for the controller and the datapath.
// ---------------------------------------------------------------------------
package rfsp_pkg;

  // One sequence step as held in the step memory.
  typedef struct packed {
    logic        fade;
    logic [15:0] dur;
    logic [23:0] rgb;
  } step_t;

  // Command kinds carried on the input tuser.
  localparam logic [3:0] K_TICK      = 4'd0;
  localparam logic [3:0] K_SET       = 4'd1;
  localparam logic [3:0] K_FADE      = 4'd2;
  localparam logic [3:0] K_START_PAT = 4'd3;
  localparam logic [3:0] K_QUEUE_PAT = 4'd4;
  localparam logic [3:0] K_START_CU  = 4'd5;
  localparam logic [3:0] K_QUEUE_CU  = 4'd6;
  localparam logic [3:0] K_QCLR      = 4'd7;
  localparam logic [3:0] K_CLRALL    = 4'd8;
  localparam logic [3:0] K_STOP      = 4'd9;

  // Built-in pattern ids.
  localparam logic [3:0] PAT_RAINBOW = 4'd0;
  localparam logic [3:0] PAT_FLASH   = 4'd1;
  localparam logic [3:0] PAT_BREATHE = 4'd2;
  localparam logic [3:0] PAT_POLICE  = 4'd3;

  // Datapath micro-operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TICK, OP_SET, OP_FADECMD, OP_HALT, OP_QCLR,
    OP_CLRALL, OP_LOAD_BI, OP_QPUSH_BI, OP_STAGE, OP_COMMIT_PLAY,
    OP_COMMIT_QUEUE, OP_QPUSH_CU, OP_COPY, OP_BEGIN, OP_FETCH, OP_START,
    OP_FADE_END, OP_BL_MUL, OP_BL_SUM, OP_BL_DIV, OP_BL_WR, OP_ADV,
    OP_WRAP, OP_END_PLAY, OP_POP, OP_COMMIT_POP, OP_RESULT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic rep;      // repeat flag for a sequence start
    logic src_pop;  // pattern comes from the popped queue entry
  } cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       last;
    logic       loop_flag;
    logic       playing;
    logic       fading;
    logic       repeat_on;
    logic       q_full;
    logic       q_any;
    logic       cnt_zero;
    logic       fade_end;
    logic       dur_done;
    logic       wrap;
    logic       cp_done;
    logic       div_last;
    logic       pop_builtin;
    logic       out_busy;
  } stat_t;

  // Number of steps in a built-in pattern; unknown ids are empty.
  function automatic logic [3:0] pat_count(input logic [3:0] p);
    logic [3:0] n;
    begin
      unique case (p)
        PAT_RAINBOW: n = 4'd6;
        PAT_FLASH:   n = 4'd2;
        PAT_BREATHE: n = 4'd2;
        PAT_POLICE:  n = 4'd8;
        default:     n = 4'd0;
      endcase
      return n;
    end
  endfunction

  // Step i of a built-in pattern at the given speed.
  function automatic step_t bi_step(input logic [3:0] p, input logic [2:0] i,
                                    input logic [15:0] spd);
    step_t s;
    begin
      s.dur  = spd;
      s.fade = 1'b0;
      s.rgb  = 24'h000000;
      unique case (p)
        PAT_RAINBOW: begin
          s.fade = 1'b1;
          unique case (i)
            3'd0:    s.rgb = 24'hFF0000;
            3'd1:    s.rgb = 24'hFF7F00;
            3'd2:    s.rgb = 24'hFFFF00;
            3'd3:    s.rgb = 24'h00FF00;
            3'd4:    s.rgb = 24'h0000FF;
            3'd5:    s.rgb = 24'h8B00FF;
            default: s.rgb = 24'h000000;
          endcase
        end
        PAT_FLASH: begin
          s.rgb = i[0] ? 24'h000000 : 24'hFFFFFF;
        end
        PAT_BREATHE: begin
          s.fade = 1'b1;
          s.rgb  = i[0] ? 24'hFFFFFF : 24'h000000;
        end
        PAT_POLICE: begin
          if (i[0]) begin
            s.rgb = 24'h000000;
            s.dur = spd >> 2;
          end else begin
            s.rgb = i[2] ? 24'h0000FF : 24'hFF0000;
            s.dur = spd >> 1;
          end
        end
        default: s.rgb = 24'h000000;
      endcase
      return s;
    end
  endfunction

endpackage

>>> design/rfsp_datapath.sv
// ---------------------------------------------------------------------------
// RGB fade sequence player datapath
// Player state, step memory with staging and queue banks, queue headers,
// fade blend unit with a bit-serial divider, and the result register.
// ---------------------------------------------------------------------------
module rfsp_datapath #(
  parameter int STEPS_MAX   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rfsp_pkg::cmd_t   cmd,
  output rfsp_pkg::stat_t  stat,
  input  logic [3:0]       in_tuser,
  input  logic [47:0]      in_tdata,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata
);
  import rfsp_pkg::*;

  localparam int IW    = $clog2(STEPS_MAX);
  localparam int CW    = IW + 1;
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int UW    = $clog2(QUEUE_DEPTH + 1);
  localparam int NB    = QUEUE_DEPTH + 2;
  localparam int BW    = $clog2(NB);
  localparam int DEPTH = NB * STEPS_MAX;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [BW-1:0] BANK_PLAY = BW'(0);
  localparam logic [BW-1:0] BANK_STG  = BW'(1);

  // Item register.
  logic [3:0]  it_kind_r;
  logic [23:0] it_rgb_r;
  logic [15:0] it_tms_r;
  logic        it_fade_r;
  logic [3:0]  it_pat_r;
  logic        it_loop_r;
  logic        it_last_r;

  // Player state.
  logic [23:0]   colour_r, fade_from_r, fade_to_r;
  logic [15:0]   fade_len_r, fade_el_r, step_el_r;
  logic          fading_r, playing_r, repeat_r;
  logic [CW-1:0] step_cnt_r, stg_cnt_r, cmt_n_r;
  logic [IW-1:0] step_idx_r;
  logic          play_bi_r;
  logic [3:0]    play_pat_r;
  logic [15:0]   play_spd_r;

  // Queue.
  logic [QW-1:0] head_r, tail_r, pop_slot_r;
  logic [UW-1:0] used_r;
  logic          hq_bi_r  [QUEUE_DEPTH];
  logic [3:0]    hq_pat_r [QUEUE_DEPTH];
  logic [15:0]   hq_spd_r [QUEUE_DEPTH];
  logic [CW-1:0] hq_cnt_r [QUEUE_DEPTH];
  logic          pop_bi_r;
  logic [3:0]    pop_pat_r;
  logic [15:0]   pop_spd_r;
  logic [CW-1:0] pop_cnt_r;

  // Copy engine.
  logic [CW-1:0] cp_k_r, cp_n_r;
  logic [BW-1:0] cp_src_r, cp_dst_r;

  // Step memory.
  step_t         mem [DEPTH];
  step_t         rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  step_t         mem_wdata;

  // Blend unit.
  logic [23:0] p1_r [3];
  logic [23:0] p2_r [3];
  logic        neg_r [3];
  logic [23:0] rem_r [3];
  logic [7:0]  q_r [3];
  logic [2:0]  div_bit_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  step_t         cur_step;
  logic          stg_room;
  logic [CW-1:0] stg_n;
  logic [3:0]    ld_pat;
  logic [15:0]   ld_spd;

  function automatic logic [AW-1:0] addr_of(input logic [BW-1:0] b,
                                            input logic [IW-1:0] i);
    return AW'(b) * AW'(STEPS_MAX) + AW'(i);
  endfunction

  function automatic logic [QW-1:0] ptr_next(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cur_step = play_bi_r ? bi_step(play_pat_r, step_idx_r[2:0], play_spd_r)
                              : rdata_r;
  assign stg_room = stg_cnt_r < CW'(STEPS_MAX);
  assign stg_n    = stg_cnt_r + CW'(stg_room);
  assign ld_pat   = cmd.src_pop ? pop_pat_r : it_pat_r;
  assign ld_spd   = cmd.src_pop ? pop_spd_r : it_tms_r;

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_of(BANK_STG, stg_cnt_r[IW-1:0]);
    mem_raddr = addr_of(BANK_PLAY, step_idx_r);
    mem_wdata = '{fade: it_fade_r, dur: it_tms_r, rgb: it_rgb_r};
    unique case (cmd.op)
      OP_STAGE: begin
        mem_we = stg_room;
      end
      OP_COPY: begin
        mem_we    = cp_k_r != '0;
        mem_waddr = addr_of(cp_dst_r, IW'(cp_k_r - 1'b1));
        mem_wdata = rdata_r;
        mem_re    = cp_k_r < cp_n_r;
        mem_raddr = addr_of(cp_src_r, cp_k_r[IW-1:0]);
      end
      OP_FETCH: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Control and player state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r    <= '0;
      fade_from_r <= '0;
      fade_to_r   <= '0;
      fade_len_r  <= '0;
      fade_el_r   <= '0;
      fading_r    <= 1'b0;
      playing_r   <= 1'b0;
      repeat_r    <= 1'b0;
      step_cnt_r  <= '0;
      step_idx_r  <= '0;
      step_el_r   <= '0;
      play_bi_r   <= 1'b0;
      play_pat_r  <= '0;
      play_spd_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      stg_cnt_r   <= '0;
      cp_k_r      <= '0;
      cp_n_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_TICK: begin
          if (fade_el_r != 16'hFFFF) fade_el_r <= fade_el_r + 16'd1;
          if (step_el_r != 16'hFFFF) step_el_r <= step_el_r + 16'd1;
        end
        OP_SET: begin
          fading_r  <= 1'b0;
          playing_r <= 1'b0;
          colour_r  <= it_rgb_r;
        end
        OP_FADECMD: begin
          playing_r   <= 1'b0;
          fade_from_r <= colour_r;
          fade_to_r   <= it_rgb_r;
          fade_len_r  <= it_tms_r;
          fade_el_r   <= '0;
          fading_r    <= 1'b1;
        end
        OP_HALT: begin
          fading_r  <= 1'b0;
          playing_r <= 1'b0;
        end
        OP_QCLR: begin
          head_r <= '0;
          tail_r <= '0;
          used_r <= '0;
        end
        OP_CLRALL: begin
          head_r    <= '0;
          tail_r    <= '0;
          used_r    <= '0;
          fading_r  <= 1'b0;
          playing_r <= 1'b0;
          colour_r  <= '0;
          stg_cnt_r <= '0;
        end
        OP_LOAD_BI: begin
          fading_r   <= 1'b0;
          playing_r  <= 1'b0;
          play_bi_r  <= 1'b1;
          play_pat_r <= ld_pat;
          play_spd_r <= ld_spd;
          step_cnt_r <= CW'(pat_count(ld_pat));
        end
        OP_QPUSH_BI, OP_QPUSH_CU: begin
          tail_r <= ptr_next(tail_r);
          used_r <= used_r + 1'b1;
        end
        OP_STAGE: begin
          if (it_last_r) begin
            stg_cnt_r <= '0;
          end else if (stg_room) begin
            stg_cnt_r <= stg_cnt_r + 1'b1;
          end
        end
        OP_COMMIT_PLAY: begin
          fading_r   <= 1'b0;
          playing_r  <= 1'b0;
          play_bi_r  <= 1'b0;
          step_cnt_r <= cmt_n_r;
          cp_k_r     <= '0;
          cp_n_r     <= cmt_n_r;
        end
        OP_COMMIT_QUEUE: begin
          cp_k_r <= '0;
          cp_n_r <= cmt_n_r;
        end
        OP_COMMIT_POP: begin
          play_bi_r  <= 1'b0;
          step_cnt_r <= pop_cnt_r;
          cp_k_r     <= '0;
          cp_n_r     <= pop_cnt_r;
        end
        OP_COPY: begin
          if (cp_k_r < cp_n_r) cp_k_r <= cp_k_r + 1'b1;
        end
        OP_BEGIN: begin
          step_idx_r <= '0;
          step_el_r  <= '0;
          playing_r  <= 1'b1;
          repeat_r   <= cmd.rep;
        end
        OP_START: begin
          if (cur_step.fade) begin
            fade_from_r <= colour_r;
            fade_to_r   <= cur_step.rgb;
            fade_len_r  <= cur_step.dur;
            fade_el_r   <= '0;
            fading_r    <= 1'b1;
          end else begin
            colour_r <= cur_step.rgb;
          end
        end
        OP_FADE_END: begin
          colour_r <= fade_to_r;
          fading_r <= 1'b0;
        end
        OP_BL_WR: begin
          colour_r <= {q_r[2], q_r[1], q_r[0]};
        end
        OP_ADV: begin
          step_idx_r <= step_idx_r + 1'b1;
          step_el_r  <= '0;
        end
        OP_WRAP: begin
          step_idx_r <= '0;
          step_el_r  <= '0;
        end
        OP_END_PLAY: begin
          playing_r <= 1'b0;
          if (used_r == '0) colour_r <= '0;
        end
        OP_POP: begin
          head_r <= ptr_next(head_r);
          used_r <= used_r - 1'b1;
        end
        default: begin
          fading_r <= fading_r;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        it_kind_r <= in_tuser;
        it_rgb_r  <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
        it_tms_r  <= in_tdata[39:24];
        it_fade_r <= in_tdata[40];
        it_pat_r  <= in_tdata[44:41];
        it_loop_r <= in_tdata[45];
        it_last_r <= in_tlast;
      end
      OP_QPUSH_BI: begin
        hq_bi_r[tail_r]  <= 1'b1;
        hq_pat_r[tail_r] <= it_pat_r;
        hq_spd_r[tail_r] <= it_tms_r;
        hq_cnt_r[tail_r] <= '0;
      end
      OP_QPUSH_CU: begin
        hq_bi_r[tail_r]  <= 1'b0;
        hq_pat_r[tail_r] <= '0;
        hq_spd_r[tail_r] <= '0;
        hq_cnt_r[tail_r] <= cmt_n_r;
      end
      OP_STAGE: begin
        if (it_last_r) cmt_n_r <= stg_n;
      end
      OP_COMMIT_PLAY: begin
        cp_src_r <= BANK_STG;
        cp_dst_r <= BANK_PLAY;
      end
      OP_COMMIT_QUEUE: begin
        cp_src_r <= BANK_STG;
        cp_dst_r <= BW'(tail_r) + BW'(2);
      end
      OP_COMMIT_POP: begin
        cp_src_r <= BW'(pop_slot_r) + BW'(2);
        cp_dst_r <= BANK_PLAY;
      end
      OP_POP: begin
        pop_slot_r <= head_r;
        pop_bi_r   <= hq_bi_r[head_r];
        pop_pat_r  <= hq_pat_r[head_r];
        pop_spd_r  <= hq_spd_r[head_r];
        pop_cnt_r  <= hq_cnt_r[head_r];
      end
      OP_BL_MUL: begin
        for (int c = 0; c < 3; c++) begin
          p1_r[c]  <= 24'(fade_from_r[8*c +: 8]) * 24'(fade_len_r);
          p2_r[c]  <= 24'((fade_to_r[8*c +: 8] >= fade_from_r[8*c +: 8])
                        ? (fade_to_r[8*c +: 8] - fade_from_r[8*c +: 8])
                        : (fade_from_r[8*c +: 8] - fade_to_r[8*c +: 8]))
                      * 24'(fade_el_r);
          neg_r[c] <= fade_to_r[8*c +: 8] < fade_from_r[8*c +: 8];
        end
        div_bit_r <= 3'd7;
      end
      OP_BL_SUM: begin
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= neg_r[c] ? (p1_r[c] - p2_r[c]) : (p1_r[c] + p2_r[c]);
          q_r[c]   <= '0;
        end
      end
      OP_BL_DIV: begin
        // One quotient bit per cycle for all three channels.
        for (int c = 0; c < 3; c++) begin
          if (rem_r[c] >= (24'(fade_len_r) << div_bit_r)) begin
            rem_r[c]           <= rem_r[c] - (24'(fade_len_r) << div_bit_r);
            q_r[c][div_bit_r]  <= 1'b1;
          end
        end
        div_bit_r <= div_bit_r - 3'd1;
      end
      OP_RESULT: begin
        out_data_r <= {3'b000, 3'(used_r), playing_r, fading_r,
                       colour_r[7:0], colour_r[15:8], colour_r[23:16]};
      end
      default: begin
        it_kind_r <= it_kind_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    stat.kind        = it_kind_r;
    stat.last        = it_last_r;
    stat.loop_flag   = it_loop_r;
    stat.playing     = playing_r;
    stat.fading      = fading_r;
    stat.repeat_on   = repeat_r;
    stat.q_full      = used_r >= UW'(QUEUE_DEPTH);
    stat.q_any       = used_r != '0;
    stat.cnt_zero    = step_cnt_r == '0;
    stat.fade_end    = fade_el_r >= fade_len_r;
    stat.dur_done    = step_el_r >= cur_step.dur;
    stat.wrap        = (CW'(step_idx_r) + CW'(1)) >= step_cnt_r;
    stat.cp_done     = cp_k_r == cp_n_r;
    stat.div_last    = div_bit_r == 3'd0;
    stat.pop_builtin = pop_bi_r;
    stat.out_busy    = out_valid_r && !out_tready;
  end

endmodule

>>> design/rfsp_ctrl.sv
// ---------------------------------------------------------------------------
// RGB fade sequence player controller
// Sequences the datapath micro-operations for each command word.
// ---------------------------------------------------------------------------
module rfsp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  rfsp_pkg::stat_t stat,
  input  logic            in_tvalid,
  output logic            in_tready,
  output rfsp_pkg::cmd_t  cmd
);
  import rfsp_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_PAT_CHK  = 5'd2;
  localparam logic [4:0] S_POP_CHK  = 5'd3;
  localparam logic [4:0] S_FETCH    = 5'd4;
  localparam logic [4:0] S_START    = 5'd5;
  localparam logic [4:0] S_COMMIT   = 5'd6;
  localparam logic [4:0] S_COPY     = 5'd7;
  localparam logic [4:0] S_QPUSH    = 5'd8;
  localparam logic [4:0] S_BEGIN    = 5'd9;
  localparam logic [4:0] S_TICKFADE = 5'd10;
  localparam logic [4:0] S_BL_SUM   = 5'd11;
  localparam logic [4:0] S_BL_DIV   = 5'd12;
  localparam logic [4:0] S_BL_WR    = 5'd13;
  localparam logic [4:0] S_SEQ      = 5'd14;
  localparam logic [4:0] S_SEQ_CHK  = 5'd15;
  localparam logic [4:0] S_POP      = 5'd16;
  localparam logic [4:0] S_POP_LOAD = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       rep_r, rep_nxt;
  logic       to_q_r, to_q_nxt;
  logic       idle_play;

  assign idle_play = !stat.playing && !stat.fading;
  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    rep_nxt     = rep_r;
    to_q_nxt    = to_q_r;
    cmd.op      = OP_NONE;
    cmd.rep     = rep_r;
    cmd.src_pop = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (stat.kind)
          K_TICK: begin
            cmd.op    = OP_TICK;
            state_nxt = S_TICKFADE;
          end
          K_SET:    cmd.op = OP_SET;
          K_FADE:   cmd.op = OP_FADECMD;
          K_STOP:   cmd.op = OP_HALT;
          K_QCLR:   cmd.op = OP_QCLR;
          K_CLRALL: cmd.op = OP_CLRALL;
          K_START_PAT: begin
            cmd.op    = OP_LOAD_BI;
            rep_nxt   = 1'b1;
            state_nxt = S_PAT_CHK;
          end
          K_QUEUE_PAT: begin
            if (stat.q_full) begin
              cmd.op = OP_NONE;
            end else if (idle_play) begin
              cmd.op    = OP_LOAD_BI;
              rep_nxt   = 1'b0;
              state_nxt = S_PAT_CHK;
            end else begin
              cmd.op = OP_QPUSH_BI;
            end
          end
          K_START_CU, K_QUEUE_CU: begin
            cmd.op = OP_STAGE;
            if (stat.last) state_nxt = S_COMMIT;
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_PAT_CHK: begin
        if (stat.cnt_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_BEGIN;
          state_nxt = S_FETCH;
        end
      end
      S_POP_CHK: begin
        if (stat.cnt_zero) begin
          state_nxt = S_POP;
        end else begin
          cmd.op    = OP_BEGIN;
          cmd.rep   = 1'b0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.op    = OP_FETCH;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.op    = OP_START;
        state_nxt = S_DONE;
      end
      S_COMMIT: begin
        if (stat.kind == K_START_CU) begin
          cmd.op    = OP_COMMIT_PLAY;
          rep_nxt   = stat.loop_flag;
          to_q_nxt  = 1'b0;
          state_nxt = S_COPY;
        end else if (stat.q_full) begin
          state_nxt = S_DONE;
        end else if (idle_play) begin
          cmd.op    = OP_COMMIT_PLAY;
          rep_nxt   = 1'b0;
          to_q_nxt  = 1'b0;
          state_nxt = S_COPY;
        end else begin
          cmd.op    = OP_COMMIT_QUEUE;
          to_q_nxt  = 1'b1;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.op = OP_COPY;
        if (stat.cp_done) state_nxt = to_q_r ? S_QPUSH : S_BEGIN;
      end
      S_QPUSH: begin
        cmd.op    = OP_QPUSH_CU;
        state_nxt = S_DONE;
      end
      S_BEGIN: begin
        cmd.op    = OP_BEGIN;
        state_nxt = S_FETCH;
      end
      S_TICKFADE: begin
        state_nxt = S_SEQ;
        if (stat.fading) begin
          if (stat.fade_end) begin
            cmd.op = OP_FADE_END;
          end else begin
            cmd.op    = OP_BL_MUL;
            state_nxt = S_BL_SUM;
          end
        end
      end
      S_BL_SUM: begin
        cmd.op    = OP_BL_SUM;
        state_nxt = S_BL_DIV;
      end
      S_BL_DIV: begin
        cmd.op = OP_BL_DIV;
        if (stat.div_last) state_nxt = S_BL_WR;
      end
      S_BL_WR: begin
        cmd.op    = OP_BL_WR;
        state_nxt = S_SEQ;
      end
      S_SEQ: begin
        if (stat.playing && !stat.fading) begin
          cmd.op    = OP_FETCH;
          state_nxt = S_SEQ_CHK;
        end else if (idle_play && stat.q_any) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SEQ_CHK: begin
        if (!stat.dur_done) begin
          state_nxt = S_DONE;
        end else if (!stat.wrap) begin
          cmd.op    = OP_ADV;
          state_nxt = S_FETCH;
        end else if (stat.repeat_on) begin
          cmd.op    = OP_WRAP;
          state_nxt = S_FETCH;
        end else begin
          cmd.op    = OP_END_PLAY;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (stat.q_any) begin
          cmd.op    = OP_POP;
          state_nxt = S_POP_LOAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP_LOAD: begin
        if (stat.pop_builtin) begin
          cmd.op      = OP_LOAD_BI;
          cmd.src_pop = 1'b1;
          state_nxt   = S_POP_CHK;
        end else begin
          cmd.op    = OP_COMMIT_POP;
          rep_nxt   = 1'b0;
          to_q_nxt  = 1'b0;
          state_nxt = S_COPY;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rep_r   <= 1'b0;
      to_q_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rep_r   <= rep_nxt;
      to_q_r  <= to_q_nxt;
    end
  end

endmodule

>>> design/rgb_fade_sequence_player.sv
// ---------------------------------------------------------------------------
// RGB fade sequence player
// Drives an RGB LED level from tick and command words: colours, fades,
// built-in patterns, custom step sequences and a queue of sequences.
// ---------------------------------------------------------------------------
// Usage: every input word carries one command, its kind on in_tuser and the
// custom-step end marker on in_tlast. Every accepted word returns exactly one
// result word with the LED level, the fade and play flags and the queue fill.
// A tick that blends a fade uses the bit-serial restoring divider. Committing
// a custom sequence, or handing the queue over to a custom sequence, copies
// its steps through the step memory at one step per cycle; empty queue
// entries are skipped. The block takes one word at a time: in_tready is high
// only while it waits for a word. The result sits in an output register, so
// the next word is taken while that result still waits; a stalled receiver
// holds the block only when a second result is ready.
// After reset the LED is off, nothing plays, the queue is empty and the
// step memory holds nothing that is ever read before it is written.
// ---------------------------------------------------------------------------
module rgb_fade_sequence_player #(
  parameter int STEPS_MAX   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata from bit 0: red[7:0], green[15:8], blue[23:16], time_ms[39:24],
  // fade[40], pattern[44:41], loop[45], zero fill[47:46].
  input  logic [47:0] in_tdata,
  // in_tuser: kind[3:0].
  input  logic [3:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata from bit 0: out_red[7:0], out_green[15:8], out_blue[23:16],
  // is_fading[24], is_playing[25], queue_length[28:26], zero fill[31:29].
  output logic [31:0] out_tdata
);
  import rfsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller walks each command through its micro-operations.
  rfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // The datapath holds all player state, the step memory and the divider.
  rfsp_datapath #(
    .STEPS_MAX   (STEPS_MAX),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> design/rfsp_checker.sv
// ---------------------------------------------------------------------------
// RGB fade sequence player checker
// Port-level checks on the player, attached to the top level by bind.
// ---------------------------------------------------------------------------
module rfsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // Every word needs decoding, so the block is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted back to back");

endmodule

bind rgb_fade_sequence_player rfsp_checker u_rfsp_checker (.*);
